>>> rtl/assert_macros.svh
// assertion macros shared by the rtl files
// each use samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every sampled edge
`define BGHM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define BGHM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BGHM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/bghm_pkg.sv
// shared constants of the block intensity histogram
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bghm_pkg;

  localparam int CNT_W   = 17;
  localparam int QUO_W   = 17;
  localparam int FRAC_W  = 16;
  localparam int DIM_W   = 11;
  localparam int POS_W   = 10;
  localparam int SUB_W   = 8;
  localparam int BIN_W   = 4;
  localparam int BLK_W   = 2;
  localparam int ADDR_W  = BLK_W + BIN_W;
  localparam int NBINS   = 1 << BIN_W;
  localparam int NBLK    = 1 << BLK_W;
  localparam int DEPTH   = NBINS * NBLK;
  localparam int STEP_W  = 5;

  localparam logic [DIM_W-1:0] DIM_MIN     = 11'd4;
  localparam logic [DIM_W-1:0] DIM_MAX     = 11'd1024;
  localparam logic [DIM_W-1:0] DIM_RESET   = 11'd80;
  localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [QUO_W-1:0] quo_t;

endpackage

`default_nettype wire

>>> rtl/bghm_sdiv.sv
// bit-serial restoring divider, one quotient bit per cycle
// computes (num << 16) / den for num <= den; depends on bghm_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bghm_sdiv (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               load,
  input  wire bghm_pkg::cnt_t num,
  input  wire bghm_pkg::cnt_t den,
  output logic              done,
  output bghm_pkg::quo_t    quo
);
  import bghm_pkg::*;

  cnt_t              rem_r, rem_nxt;
  quo_t              quo_r;
  logic [STEP_W-1:0] k_r;
  logic              run_r;
  logic              done_r;
  logic [CNT_W:0]    trial;
  logic              ge;

  always_comb begin
    if (k_r == '0) begin
      trial = {1'b0, rem_r};
    end else begin
      trial = {rem_r, 1'b0};
    end
    ge = (trial >= {1'b0, den});
    if (ge) begin
      rem_nxt = CNT_W'(trial - {1'b0, den});
    end else begin
      rem_nxt = CNT_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (load) begin
        run_r <= 1'b1;
        k_r   <= '0;
      end else if (run_r) begin
        k_r <= k_r + 1'b1;
        if (k_r == STEP_W'(FRAC_W)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= num;
      quo_r <= '0;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

  `BGHM_ASSERT_IMP(a_load_idle, load, !run_r, "divider loaded while running")
  `BGHM_ASSERT_IMP(a_done_stop, done_r, !run_r, "divider done while still running")
  `BGHM_ASSERT_NXT(a_done_len, run_r && k_r == STEP_W'(FRAC_W) && !load, done_r,
    "divider finished without done")

endmodule

`default_nettype wire

>>> rtl/block_gray_histogram_minmax.sv
// top level of the 4x4 patch intensity histogram with min-max normalization
// holds the bin memory and sequencer; depends on bghm_pkg and bghm_sdiv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Usage:
// Pixels enter in raster order: a pixel is taken at a clock edge with start
// high and busy low. Each pixel gets a bin memory read at that edge, then the
// saturating write back, so busy is high for one cycle after each pixel that
// starts no burst. The last counted pixel of a patch row starts a burst of 64
// results, one per patch column and bin. Per patch column the sequencer runs
// the min/max scan of its 16 bins, then for each value a bin read, a divider
// load and a wait while the bit-serial divider finds 17 quotient bits, one per
// cycle. A burst keeps busy high throughout; the last value carries out_last.
// Each result is shown for one cycle with out_strobe; the receiver cannot
// stall, so nothing is held back. Bins are cleared as they are read during
// a burst. cfg_we writes image_width (index 0) or image_height (index 1),
// restarts the frame and runs a clearing pass over all 64 bin memory
// entries, busy high. Reset loads 80 x 80 and runs the same clearing pass.

module block_gray_histogram_minmax (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  output logic       busy,
  input  wire  [7:0] in_pixel,
  input  wire        cfg_we,
  input  wire  [1:0] cfg_index,
  input  wire [10:0] cfg_data,
  output logic        out_strobe,
  output logic [16:0] out_feature_value,
  output logic [1:0]  out_block_row,
  output logic [1:0]  out_block_col,
  output logic [3:0]  out_bin_index,
  output logic        out_flat_patch,
  output logic        out_last
);
  import bghm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_MM   = 3'd2;
  localparam logic [2:0] S_DRD  = 3'd3;
  localparam logic [2:0] S_DLD  = 3'd4;
  localparam logic [2:0] S_DWT  = 3'd5;
  localparam logic [2:0] S_CLR  = 3'd6;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v < DIM_MIN) begin
      r = DIM_MIN;
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [2:0]        state_r;
  logic [DIM_W-1:0]  width_r, height_r;
  logic [POS_W-1:0]  col_r, row_r;
  logic [SUB_W-1:0]  cip_r, rip_r;
  logic [BLK_W:0]    pc_r, pr_r;
  logic [SUB_W-1:0]  pw_m1, ph_m1;
  logic              col_wrap, row_wrap;

  cnt_t              mem [DEPTH];
  cnt_t              rd_data_r;
  logic [ADDR_W-1:0] mem_raddr, mem_waddr;
  cnt_t              mem_wdata;
  logic              mem_we;

  logic [ADDR_W-1:0] upd_addr_r;
  logic              counted_r, burst_r;
  logic [BLK_W-1:0]  brow_r;
  logic [BLK_W-1:0]  c_r;
  logic [BIN_W-1:0]  b_r;
  logic [STEP_W-1:0] mm_cnt_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  cnt_t              lo_r, hi_r, den_r;
  logic              flat_r;

  logic              accept, counted, burst, cfg_hit;
  cnt_t              div_num;
  logic              div_load, div_done;
  quo_t              div_quo;

  logic        out_strobe_r;
  logic [16:0] out_value_r;
  logic [1:0]  out_row_r, out_col_r;
  logic [3:0]  out_bin_r;
  logic        out_flat_r, out_last_r;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign cfg_hit  = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);
  assign pw_m1    = SUB_W'(width_r[DIM_W-1:BLK_W] - 9'd1);
  assign ph_m1    = SUB_W'(height_r[DIM_W-1:BLK_W] - 9'd1);
  assign col_wrap = ({1'b0, col_r} + 11'd1) >= width_r;
  assign row_wrap = ({1'b0, row_r} + 11'd1) >= height_r;
  assign counted  = !pc_r[BLK_W] && !pr_r[BLK_W];
  assign burst    = counted && (pc_r[BLK_W-1:0] == BLK_W'(NBLK - 1))
                    && (cip_r == pw_m1) && (rip_r == ph_m1);
  assign div_num  = rd_data_r - lo_r;
  assign div_load = (state_r == S_DLD);

  // memory address and write selection
  always_comb begin
    mem_raddr = {pc_r[BLK_W-1:0], in_pixel[7:4]};
    mem_we    = 1'b0;
    mem_waddr = upd_addr_r;
    mem_wdata = '0;
    case (state_r)
      S_UPD: begin
        mem_we = counted_r;
        if (rd_data_r == CNT_MAX) begin
          mem_wdata = rd_data_r;
        end else begin
          mem_wdata = rd_data_r + 1'b1;
        end
      end
      S_MM: begin
        mem_raddr = {c_r, mm_cnt_r[BIN_W-1:0]};
      end
      S_DRD: begin
        mem_raddr = {c_r, b_r};
        mem_we    = 1'b1;
        mem_waddr = {c_r, b_r};
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // sequencer and raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_cnt_r <= '0;
      width_r   <= DIM_RESET;
      height_r  <= DIM_RESET;
      col_r     <= '0;
      row_r     <= '0;
      cip_r     <= '0;
      rip_r     <= '0;
      pc_r      <= '0;
      pr_r      <= '0;
      mm_cnt_r  <= '0;
      c_r       <= '0;
      b_r       <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == REG_WIDTH) begin
        width_r <= clamp_dim(cfg_data);
      end else begin
        height_r <= clamp_dim(cfg_data);
      end
      state_r   <= S_CLR;
      clr_cnt_r <= '0;
      col_r     <= '0;
      row_r     <= '0;
      cip_r     <= '0;
      rip_r     <= '0;
      pc_r      <= '0;
      pr_r      <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_UPD;
            if (col_wrap) begin
              col_r <= '0;
              cip_r <= '0;
              pc_r  <= '0;
              if (row_wrap) begin
                row_r <= '0;
                rip_r <= '0;
                pr_r  <= '0;
              end else begin
                row_r <= row_r + 1'b1;
                if (rip_r == ph_m1) begin
                  rip_r <= '0;
                  pr_r  <= pr_r + 1'b1;
                end else begin
                  rip_r <= rip_r + 1'b1;
                end
              end
            end else begin
              col_r <= col_r + 1'b1;
              if (cip_r == pw_m1) begin
                cip_r <= '0;
                pc_r  <= pc_r + 1'b1;
              end else begin
                cip_r <= cip_r + 1'b1;
              end
            end
          end
        end
        S_UPD: begin
          if (burst_r) begin
            state_r  <= S_MM;
            c_r      <= '0;
            mm_cnt_r <= '0;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_MM: begin
          mm_cnt_r <= mm_cnt_r + 1'b1;
          if (mm_cnt_r == STEP_W'(NBINS)) begin
            state_r <= S_DRD;
            b_r     <= '0;
          end
        end
        S_DRD: begin
          state_r <= S_DLD;
        end
        S_DLD: begin
          state_r <= S_DWT;
        end
        S_DWT: begin
          if (div_done) begin
            if (b_r == BIN_W'(NBINS - 1)) begin
              if (c_r == BLK_W'(NBLK - 1)) begin
                state_r <= S_IDLE;
              end else begin
                c_r      <= c_r + 1'b1;
                mm_cnt_r <= '0;
                state_r  <= S_MM;
              end
            end else begin
              b_r     <= b_r + 1'b1;
              state_r <= S_DRD;
            end
          end
        end
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // per-transaction and min/max data
  always_ff @(posedge clk) begin
    if (accept) begin
      upd_addr_r <= mem_raddr;
      counted_r  <= counted;
      burst_r    <= burst;
      brow_r     <= pr_r[BLK_W-1:0];
    end
    if (state_r == S_MM) begin
      if (mm_cnt_r == STEP_W'(1)) begin
        lo_r <= rd_data_r;
        hi_r <= rd_data_r;
      end else if (mm_cnt_r != '0) begin
        if (rd_data_r < lo_r) begin
          lo_r <= rd_data_r;
        end
        if (rd_data_r > hi_r) begin
          hi_r <= rd_data_r;
        end
      end
    end
    if (state_r == S_DRD) begin
      den_r  <= hi_r - lo_r;
      flat_r <= (hi_r == lo_r);
    end
  end

  bghm_sdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (div_load),
    .num   (div_num),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (state_r == S_DWT) && div_done && !cfg_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DWT && div_done) begin
      out_value_r <= flat_r ? '0 : div_quo;
      out_row_r   <= brow_r;
      out_col_r   <= c_r;
      out_bin_r   <= b_r;
      out_flat_r  <= flat_r;
      out_last_r  <= (c_r == BLK_W'(NBLK - 1)) && (b_r == BIN_W'(NBINS - 1));
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_feature_value = out_value_r;
  assign out_block_row     = out_row_r;
  assign out_block_col     = out_col_r;
  assign out_bin_index     = out_bin_r;
  assign out_flat_patch    = out_flat_r;
  assign out_last          = out_last_r;

  `BGHM_ASSERT_IMP(a_strobe_src, out_strobe_r, $past(state_r) == S_DWT,
    "result strobe without a finished division")
  `BGHM_ASSERT_IMP(a_last_idle, out_strobe_r && out_last_r,
    state_r == S_IDLE || state_r == S_CLR, "burst ended but sequencer still active")
  `BGHM_ASSERT_NXT(a_accept_upd, accept && !cfg_hit, state_r == S_UPD,
    "accepted pixel not followed by bin update")
  `BGHM_ASSERT_IMP(a_flat_zero, out_strobe_r && out_flat_r, out_value_r == '0,
    "flat patch with nonzero value")

endmodule

`default_nettype wire
